// ===== rtl/tpe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared widths, constants and transaction types of the track pointing
// error block.
// ----------------------------------------------------------------------------
package tpe_pkg;

    localparam int DATA_W     = 32;
    localparam int VAR_W      = DATA_W - 1;
    localparam int FRAC       = 16;
    localparam int COEF       = 30;

    localparam int DEN_W      = 2 * DATA_W;
    localparam int DIV_Q      = 32;
    localparam int NUM_W      = DEN_W + DIV_Q;

    localparam int ROOT_W     = 38;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0]   slope_x;
        logic signed [DATA_W-1:0]   slope_y;
        logic [VAR_W-1:0]           var_x;
        logic [VAR_W-1:0]           var_y;
        logic signed [DATA_W-1:0]   cov_xy;
        logic [DEN_W-2:0]           x2;
        logic [DEN_W-2:0]           y2;
        logic signed [DEN_W-1:0]    xy;
    } item_t;

    typedef struct packed {
        logic [VAR_W-1:0]           exx;
        logic [VAR_W-1:0]           eyy;
        logic signed [DATA_W-1:0]   exy;
    } err_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/track_pointing_error.sv =====
// ----------------------------------------------------------------------------
// track_pointing_error
// Pointing error of a track: square root of the largest eigenvalue of the
// covariance of the unit pointing vector, unsigned Q15.16 fixed point.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  slope_x, slope_y, var_x, var_y, cov_xy
//   output   out_valid/out_stall  pointing_error, saturated
//
// One transaction per cycle sustained while the output is not stalled; the
// path from input to result runs through the 32-stage coefficient dividers
// and the two 38-stage square root pipelines.
// Reset clears the valid chain and queue; no clearing pass is needed.
// A stalled output freezes the whole back pipeline; the four-entry queue
// and input register absorb input until the queue fills.
// ----------------------------------------------------------------------------
module track_pointing_error
    import tpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] slope_x,
    input  logic signed [DATA_W-1:0] slope_y,
    input  logic [VAR_W-1:0]         var_x,
    input  logic [VAR_W-1:0]         var_y,
    input  logic signed [DATA_W-1:0] cov_xy,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [VAR_W-1:0]         pointing_error,
    output logic                     saturated
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    item_t   wr_item;
    item_t   rd_item;

    tpe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .slope_x  (slope_x),
        .slope_y  (slope_y),
        .var_x    (var_x),
        .var_y    (var_y),
        .cov_xy   (cov_xy),
        .q_stat   (q_stat),
        .push     (push),
        .item     (wr_item)
    );

    tpe_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    tpe_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_item         (rd_item),
        .q_stat         (q_stat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pointing_error (pointing_error),
        .saturated      (saturated)
    );

endmodule

// ===== rtl/tpe_front.sv =====
// ----------------------------------------------------------------------------
// tpe_front
// Input stage: accepts a transaction, forms the slope products and hands
// the item to the queue.
// ----------------------------------------------------------------------------
module tpe_front
    import tpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [DATA_W-1:0] slope_x,
    input  logic signed [DATA_W-1:0] slope_y,
    input  logic [VAR_W-1:0]         var_x,
    input  logic [VAR_W-1:0]         var_y,
    input  logic signed [DATA_W-1:0] cov_xy,
    input  q_stat_t                  q_stat,
    output logic                     push,
    output item_t                    item
);

    logic                     valid_reg;
    logic                     valid_next;
    item_t                    item_reg;
    logic                     accept;
    logic signed [DEN_W-1:0]  px2;
    logic signed [DEN_W-1:0]  py2;
    logic signed [DEN_W-1:0]  pxy;

    assign in_stall = valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_stat.full;
    assign item     = item_reg;

    always_comb
    begin
        px2 = slope_x * slope_x;
        py2 = slope_y * slope_y;
        pxy = slope_x * slope_y;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.slope_x <= slope_x;
            item_reg.slope_y <= slope_y;
            item_reg.var_x   <= var_x;
            item_reg.var_y   <= var_y;
            item_reg.cov_xy  <= cov_xy;
            item_reg.x2      <= px2[DEN_W-2:0];
            item_reg.y2      <= py2[DEN_W-2:0];
            item_reg.xy      <= pxy;
        end
    end

endmodule

// ===== rtl/tpe_queue.sv =====
// ----------------------------------------------------------------------------
// tpe_queue
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module tpe_queue
    import tpe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   wr_item,
    input  logic    pop,
    output item_t   rd_item,
    output q_stat_t stat
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_item    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count above depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !stat.full && !pop) |=>
        count_reg == (QPTR_W+1)'($past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == QPTR_W'(rd_ptr_reg + count_reg[QPTR_W-1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/tpe_div.sv =====
// ----------------------------------------------------------------------------
// tpe_div
// Pipelined restoring divider, one quotient bit per stage, truncating
// toward zero on a sign-magnitude numerator.
// ----------------------------------------------------------------------------
module tpe_div
    import tpe_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [NUM_W-1:0]         num,
    input  logic                     neg,
    input  logic [DEN_W-1:0]         den,
    output logic signed [DATA_W-1:0] quot
);

    logic [DEN_W-1:0] r_reg  [DIV_Q+1];
    logic [DIV_Q-1:0] lo_reg [DIV_Q+1];
    logic [DIV_Q-1:0] q_reg  [DIV_Q+1];
    logic [DEN_W-1:0] d_reg  [DIV_Q+1];
    logic             n_reg  [DIV_Q+1];
    logic [DEN_W:0]   t      [DIV_Q];
    logic [DEN_W+1:0] diff   [DIV_Q];
    logic             ge     [DIV_Q];

    always_comb
    begin
        for (int k = 0; k < DIV_Q; k++)
        begin
            t[k]    = {r_reg[k], lo_reg[k][DIV_Q-1]};
            diff[k] = {1'b0, t[k]} - {2'b00, d_reg[k]};
            ge[k]   = !diff[k][DEN_W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]  <= num[NUM_W-1:DIV_Q];
            lo_reg[0] <= num[DIV_Q-1:0];
            q_reg[0]  <= '0;
            d_reg[0]  <= den;
            n_reg[0]  <= neg;
            for (int k = 0; k < DIV_Q; k++)
            begin
                r_reg[k+1]  <= ge[k] ? diff[k][DEN_W-1:0] : t[k][DEN_W-1:0];
                lo_reg[k+1] <= {lo_reg[k][DIV_Q-2:0], 1'b0};
                q_reg[k+1]  <= {q_reg[k][DIV_Q-2:0], ge[k]};
                d_reg[k+1]  <= d_reg[k];
                n_reg[k+1]  <= n_reg[k];
            end
        end
    end

    assign quot = n_reg[DIV_Q] ? -$signed(q_reg[DIV_Q]) : $signed(q_reg[DIV_Q]);

endmodule

// ===== rtl/tpe_sqrt.sv =====
// ----------------------------------------------------------------------------
// tpe_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module tpe_sqrt
    import tpe_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS+1];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS+1];
    logic [RAD_W-1:0]  rad_reg  [SQRT_STEPS+1];
    logic [REM_W-1:0]  rem_t    [SQRT_STEPS];
    logic [REM_W-1:0]  trial    [SQRT_STEPS];
    logic              ge       [SQRT_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            rem_t[k] = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1:RAD_W-2]};
            trial[k] = REM_W'({root_reg[k], 2'b01});
            ge[k]    = (rem_t[k] >= trial[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            rad_reg[0]  <= rad;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                rem_reg[k+1]  <= ge[k] ? (rem_t[k] - trial[k]) : rem_t[k];
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], ge[k]};
                rad_reg[k+1]  <= {rad_reg[k][RAD_W-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

// ===== rtl/tpe_back.sv =====
// ----------------------------------------------------------------------------
// tpe_back
// Execution pipeline: coefficient division, covariance of the pointing
// vector, discriminant, two square roots and the output register.
// ----------------------------------------------------------------------------
module tpe_back
    import tpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             q_item,
    input  q_stat_t           q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [VAR_W-1:0]  pointing_error,
    output logic              saturated
);

    localparam int CA = 0;
    localparam int CB = 1;
    localparam int CX = 2;
    localparam int CY = 3;
    localparam int CP = 4;
    localparam int CI = 5;
    localparam int TA = 6;
    localparam int TB = 7;

    localparam int A2  = 0;
    localparam int B2  = 1;
    localparam int P2  = 2;
    localparam int PA  = 3;
    localparam int PB  = 4;
    localparam int XX  = 5;
    localparam int YY  = 6;
    localparam int XYC = 7;
    localparam int XP  = 8;
    localparam int YB  = 9;
    localparam int YP  = 10;
    localparam int XA  = 11;
    localparam int X2B = 12;
    localparam int Y2A = 13;

    localparam int OP_A [14] = '{CA, CB, CP, CP, CP, CX, CY, CX, CX, CY, CY, CX, CX, CY};
    localparam int OP_B [14] = '{CA, CB, CP, CA, CB, CX, CY, CY, CP, CB, CP, CA, TB, TA};
    localparam int SQ_A [9]  = '{0, 1, 2, 0, 0, 1, 3, 4, 5};
    localparam int SQ_B [9]  = '{0, 1, 2, 1, 2, 2, 3, 4, 5};

    localparam int VLAT = (DIV_Q + 1) + 9 + 4 + 2 * (SQRT_STEPS + 1);

    localparam logic [DEN_W-1:0]       ONE_Q   = DEN_W'(1) << (2 * FRAC);
    localparam logic signed [32:0]     OC      = 33'sd1 <<< COEF;
    localparam logic signed [65:0]     BIAS_C  = (66'sd1 <<< COEF) - 66'sd1;
    localparam logic signed [101:0]    BIAS_V  = (102'sd1 <<< (2 * COEF)) - 102'sd1;
    localparam logic [ROOT_W-1:0]      OUT_MAX = ROOT_W'((64'd1 << VAR_W) - 64'd1);

    logic                     en;
    logic [VLAT-1:0]          vld_reg;
    logic                     out_valid_reg;
    logic [VAR_W-1:0]         pe_reg;
    logic                     sat_reg;

    // stage 0: numerators and denominator
    logic [DEN_W-1:0]         den;
    logic [DEN_W-1:0]         one_x2;
    logic [DEN_W-1:0]         one_y2;
    logic [DATA_W-1:0]        ax;
    logic [DATA_W-1:0]        ay;
    logic [DEN_W-1:0]         axy;
    logic [NUM_W-1:0]         num  [6];
    logic                     neg  [6];
    logic signed [DATA_W-1:0] quot [6];
    err_t                     e_div_reg [DIV_Q+1];

    // coefficient and covariance stages
    logic signed [32:0]       c1_reg  [8];
    err_t                     e1_reg;
    logic signed [65:0]       mp2_reg [14];
    logic signed [32:0]       ci2_reg;
    err_t                     e2_reg;
    logic signed [65:0]       bc      [14];
    logic signed [32:0]       cm3_reg [14];
    logic signed [32:0]       ci3_reg;
    err_t                     e3_reg;
    logic signed [34:0]       tc4_reg [18];
    logic signed [32:0]       ci4_reg;
    err_t                     e4_reg;
    logic signed [31:0]       eop     [3];
    logic signed [66:0]       pr5_reg [18];
    logic signed [32:0]       ci5_reg;
    logic signed [68:0]       w6_reg  [6];
    logic signed [32:0]       ci6_reg;
    logic signed [67:0]       pl7_reg [6];
    logic signed [66:0]       ph7_reg [6];
    logic signed [101:0]      pv8_reg [6];
    logic signed [101:0]      bv      [6];
    logic signed [35:0]       v9_reg  [6];

    // discriminant stages
    logic signed [17:0]       ah      [9];
    logic signed [18:0]       al      [9];
    logic signed [17:0]       bh      [9];
    logic signed [18:0]       bl      [9];
    logic signed [35:0]       hh1_reg [9];
    logic signed [36:0]       hl1_reg [9];
    logic signed [36:0]       lh1_reg [9];
    logic signed [37:0]       ll1_reg [9];
    logic signed [37:0]       tr1_reg;
    logic signed [73:0]       pq2_reg [9];
    logic signed [37:0]       tr2_reg;
    logic signed [75:0]       sa3_reg;
    logic signed [75:0]       sb3_reg;
    logic signed [75:0]       sc3_reg;
    logic signed [37:0]       tr3_reg;
    logic signed [77:0]       d4_reg;
    logic signed [37:0]       tr4_reg;

    // square roots
    logic [RAD_W-1:0]         rad1;
    logic [ROOT_W-1:0]        ddd;
    logic signed [37:0]       tq_reg [SQRT_STEPS+1];
    logic signed [39:0]       lsum;
    logic signed [39:0]       l2;
    logic [RAD_W-1:0]         rad2;
    logic [ROOT_W-1:0]        lam;
    logic                     sat;

    assign en  = !(out_valid_reg && out_stall);
    assign pop = en && !q_stat.empty;

    always_comb
    begin
        one_x2 = ONE_Q + DEN_W'(q_item.x2);
        one_y2 = ONE_Q + DEN_W'(q_item.y2);
        den    = one_x2 + DEN_W'(q_item.y2);
        ax     = q_item.slope_x[DATA_W-1] ? unsigned'(-q_item.slope_x)
                                          : unsigned'(q_item.slope_x);
        ay     = q_item.slope_y[DATA_W-1] ? unsigned'(-q_item.slope_y)
                                          : unsigned'(q_item.slope_y);
        axy    = q_item.xy[DEN_W-1] ? unsigned'(-q_item.xy) : unsigned'(q_item.xy);
        num[CA] = NUM_W'(one_y2) << COEF;
        num[CB] = NUM_W'(one_x2) << COEF;
        num[CX] = NUM_W'(ax) << (FRAC + COEF);
        num[CY] = NUM_W'(ay) << (FRAC + COEF);
        num[CP] = NUM_W'(axy) << COEF;
        num[CI] = NUM_W'(ONE_Q) << COEF;
        neg[CA] = 1'b0;
        neg[CB] = 1'b0;
        neg[CX] = q_item.slope_x[DATA_W-1];
        neg[CY] = q_item.slope_y[DATA_W-1];
        neg[CP] = q_item.xy[DEN_W-1];
        neg[CI] = 1'b0;
    end

    for (genvar g = 0; g < 6; g++)
    begin : g_div
        tpe_div u_div
        (
            .clk  (clk),
            .en   (en),
            .num  (num[g]),
            .neg  (neg[g]),
            .den  (den),
            .quot (quot[g])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 14; k++)
        begin
            bc[k] = mp2_reg[k] + (mp2_reg[k][65] ? BIAS_C : 66'sd0);
        end
        eop[0] = $signed({1'b0, e4_reg.exx});
        eop[1] = $signed({1'b0, e4_reg.eyy});
        eop[2] = e4_reg.exy;
        for (int k = 0; k < 6; k++)
        begin
            bv[k] = pv8_reg[k] + (pv8_reg[k][101] ? BIAS_V : 102'sd0);
        end
        for (int k = 0; k < 9; k++)
        begin
            ah[k] = v9_reg[SQ_A[k]][35:18];
            al[k] = $signed({1'b0, v9_reg[SQ_A[k]][17:0]});
            bh[k] = v9_reg[SQ_B[k]][35:18];
            bl[k] = $signed({1'b0, v9_reg[SQ_B[k]][17:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_div_reg[0] <= {q_item.var_x, q_item.var_y, q_item.cov_xy};
            for (int k = 0; k < DIV_Q; k++)
            begin
                e_div_reg[k+1] <= e_div_reg[k];
            end

            for (int k = 0; k < 6; k++)
            begin
                c1_reg[k] <= 33'(quot[k]);
            end
            c1_reg[TA] <= (33'(quot[CA]) <<< 1) - OC;
            c1_reg[TB] <= (33'(quot[CB]) <<< 1) - OC;
            e1_reg     <= e_div_reg[DIV_Q];

            for (int k = 0; k < 14; k++)
            begin
                mp2_reg[k] <= c1_reg[OP_A[k]] * c1_reg[OP_B[k]];
            end
            ci2_reg <= c1_reg[CI];
            e2_reg  <= e1_reg;

            for (int k = 0; k < 14; k++)
            begin
                cm3_reg[k] <= 33'(bc[k] >>> COEF);
            end
            ci3_reg <= ci2_reg;
            e3_reg  <= e2_reg;

            tc4_reg[0]  <= 35'(cm3_reg[A2]);
            tc4_reg[1]  <= 35'(cm3_reg[P2]);
            tc4_reg[2]  <= -(35'(cm3_reg[PA]) <<< 1);
            tc4_reg[3]  <= 35'(cm3_reg[P2]);
            tc4_reg[4]  <= 35'(cm3_reg[B2]);
            tc4_reg[5]  <= -(35'(cm3_reg[PB]) <<< 1);
            tc4_reg[6]  <= 35'(cm3_reg[XX]);
            tc4_reg[7]  <= 35'(cm3_reg[YY]);
            tc4_reg[8]  <= 35'(cm3_reg[XYC]) <<< 1;
            tc4_reg[9]  <= -35'(cm3_reg[PA]);
            tc4_reg[10] <= -35'(cm3_reg[PB]);
            tc4_reg[11] <= 35'(ci3_reg) + (35'(cm3_reg[P2]) <<< 1);
            tc4_reg[12] <= 35'(cm3_reg[XP]);
            tc4_reg[13] <= -35'(cm3_reg[YB]);
            tc4_reg[14] <= -35'(cm3_reg[X2B]);
            tc4_reg[15] <= -35'(cm3_reg[XA]);
            tc4_reg[16] <= 35'(cm3_reg[YP]);
            tc4_reg[17] <= -35'(cm3_reg[Y2A]);
            ci4_reg     <= ci3_reg;
            e4_reg      <= e3_reg;

            for (int r = 0; r < 6; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pr5_reg[r*3+c] <= tc4_reg[r*3+c] * eop[c];
                end
            end
            ci5_reg <= ci4_reg;

            for (int r = 0; r < 6; r++)
            begin
                w6_reg[r] <= 69'(pr5_reg[r*3]) + 69'(pr5_reg[r*3+1])
                           + 69'(pr5_reg[r*3+2]);
            end
            ci6_reg <= ci5_reg;

            for (int k = 0; k < 6; k++)
            begin
                pl7_reg[k] <= ci6_reg * $signed({1'b0, w6_reg[k][34:0]});
                ph7_reg[k] <= ci6_reg * $signed(w6_reg[k][68:35]);
            end

            for (int k = 0; k < 6; k++)
            begin
                pv8_reg[k] <= (102'(ph7_reg[k]) <<< 35) + 102'(pl7_reg[k]);
            end

            for (int k = 0; k < 6; k++)
            begin
                v9_reg[k] <= 36'(bv[k] >>> (2 * COEF));
            end

            for (int k = 0; k < 9; k++)
            begin
                hh1_reg[k] <= ah[k] * bh[k];
                hl1_reg[k] <= ah[k] * bl[k];
                lh1_reg[k] <= al[k] * bh[k];
                ll1_reg[k] <= al[k] * bl[k];
            end
            tr1_reg <= 38'(v9_reg[0]) + 38'(v9_reg[1]) + 38'(v9_reg[2]);

            for (int k = 0; k < 9; k++)
            begin
                pq2_reg[k] <= (74'(hh1_reg[k]) <<< 36) + (74'(hl1_reg[k]) <<< 18)
                            + (74'(lh1_reg[k]) <<< 18) + 74'(ll1_reg[k]);
            end
            tr2_reg <= tr1_reg;

            sa3_reg <= 76'(pq2_reg[0]) + 76'(pq2_reg[1]) + 76'(pq2_reg[2]);
            sb3_reg <= 76'(pq2_reg[3]) + 76'(pq2_reg[4]) + 76'(pq2_reg[5]);
            sc3_reg <= 76'(pq2_reg[6]) + 76'(pq2_reg[7]) + 76'(pq2_reg[8]);
            tr3_reg <= tr2_reg;

            d4_reg  <= 78'(sa3_reg) - (78'(sb3_reg) <<< 1) + (78'(sc3_reg) <<< 2);
            tr4_reg <= tr3_reg;

            tq_reg[0] <= tr4_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                tq_reg[k+1] <= tq_reg[k];
            end

            pe_reg  <= sat ? OUT_MAX[VAR_W-1:0] : lam[VAR_W-1:0];
            sat_reg <= sat;
        end
    end

    always_comb
    begin
        rad1 = (!d4_reg[77] && d4_reg != '0) ? unsigned'(d4_reg[RAD_W-1:0]) : '0;
        lsum = 40'(tq_reg[SQRT_STEPS]) + $signed({2'b00, ddd});
        l2   = (lsum + (lsum[39] ? 40'sd1 : 40'sd0)) >>> 1;
        rad2 = l2[39] ? '0 : (RAD_W'(unsigned'(l2)) << FRAC);
        sat  = (lam > OUT_MAX);
    end

    tpe_sqrt u_sqrt_disc
    (
        .clk  (clk),
        .en   (en),
        .rad  (rad1),
        .root (ddd)
    );

    tpe_sqrt u_sqrt_out
    (
        .clk  (clk),
        .en   (en),
        .rad  (rad2),
        .root (lam)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[VLAT-2:0], pop};
            out_valid_reg <= vld_reg[VLAT-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign pointing_error = pe_reg;
    assign saturated      = sat_reg;

endmodule

// ===== bench/track_pointing_error_tb.sv =====
// ----------------------------------------------------------------------------
// track_pointing_error_tb
// Streams track slope and error items through the pointing error block with
// random gaps on both channels. A wide-integer predictor computes each
// expected pointing error and saturation flag, and the monitor compares every
// output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module track_pointing_error_tb;
    import tpe_pkg::*;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic signed [DATA_W-1:0] sx;
        logic signed [DATA_W-1:0] sy;
        logic [VAR_W-1:0]         vx;
        logic [VAR_W-1:0]         vy;
        logic signed [DATA_W-1:0] cxy;
    } track_t;

    typedef struct {
        logic [VAR_W-1:0] perr;
        logic             sat;
    } perr_t;

    localparam int LIMIT = 400000;
    localparam int N_RAND = 430;
    localparam int DRAIN_AT = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [DATA_W-1:0] slope_x = '0;
    logic signed [DATA_W-1:0] slope_y = '0;
    logic [VAR_W-1:0] var_x = '0;
    logic [VAR_W-1:0] var_y = '0;
    logic signed [DATA_W-1:0] cov_xy = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [VAR_W-1:0] pointing_error;
    logic saturated;

    track_t pending_tracks[$];
    perr_t  expected_errs[$];
    int     errors = 0;
    int     sent = 0;
    int     checked = 0;
    int     sat_seen = 0;
    int     cycles = 0;
    int     in_gap = 0;
    int     out_gap = 0;
    logic   taken = 1'b0;
    logic   fill_done = 1'b0;

    always #6 clk = ~clk;

    track_pointing_error i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .slope_x(slope_x), .slope_y(slope_y),
        .var_x(var_x), .var_y(var_y), .cov_xy(cov_xy),
        .out_valid(out_valid), .out_stall(out_stall),
        .pointing_error(pointing_error), .saturated(saturated)
    );

    function automatic wide_t shift_tz(wide_t a, int n);
        if (a < 0)
            return -((-a) >>> n);
        return a >>> n;
    endfunction

    function automatic wide_t coef_mul(wide_t a, wide_t b);
        return shift_tz(a * b, COEF);
    endfunction

    function automatic wide_t floor_root(wide_t a);
        wide_t res;
        wide_t bit_v;
        wide_t t;
        res = 0;
        bit_v = wide_t'(1) <<< 190;
        while (bit_v > a)
            bit_v = bit_v >>> 2;
        while (bit_v != 0)
        begin
            t = res + bit_v;
            if (a >= t)
            begin
                a = a - t;
                res = (res >>> 1) + bit_v;
            end
            else
                res = res >>> 1;
            bit_v = bit_v >>> 2;
        end
        return res;
    endfunction

    function automatic perr_t pointing_of(track_t tr);
        wide_t xr, yr, exx, eyy, exy, one, oc, x2, y2, xy, den;
        wide_t ca, cb, cx, cy, cp, ci;
        wide_t a2, b2, p2, pa, pb, xx, yy, xyc, xp, yb, yp, xa, x2b, y2a;
        wide_t w[6];
        wide_t v[6];
        wide_t d2, ddd, l2, lam;
        perr_t r;
        xr = tr.sx;
        yr = tr.sy;
        exx = {161'b0, tr.vx};
        eyy = {161'b0, tr.vy};
        exy = tr.cxy;
        one = wide_t'(1) <<< (2 * FRAC);
        oc = wide_t'(1) <<< COEF;
        x2 = xr * xr;
        y2 = yr * yr;
        xy = xr * yr;
        den = one + x2 + y2;
        ca = ((one + y2) <<< COEF) / den;
        cb = ((one + x2) <<< COEF) / den;
        cx = (xr <<< (FRAC + COEF)) / den;
        cy = (yr <<< (FRAC + COEF)) / den;
        cp = (xy <<< COEF) / den;
        ci = (one <<< COEF) / den;
        a2 = coef_mul(ca, ca);
        b2 = coef_mul(cb, cb);
        p2 = coef_mul(cp, cp);
        pa = coef_mul(cp, ca);
        pb = coef_mul(cp, cb);
        xx = coef_mul(cx, cx);
        yy = coef_mul(cy, cy);
        xyc = coef_mul(cx, cy);
        xp = coef_mul(cx, cp);
        yb = coef_mul(cy, cb);
        yp = coef_mul(cy, cp);
        xa = coef_mul(cx, ca);
        x2b = coef_mul(cx, (cb <<< 1) - oc);
        y2a = coef_mul(cy, (ca <<< 1) - oc);
        w[0] = a2 * exx + p2 * eyy - (pa <<< 1) * exy;
        w[1] = p2 * exx + b2 * eyy - (pb <<< 1) * exy;
        w[2] = xx * exx + yy * eyy + (xyc <<< 1) * exy;
        w[3] = -pa * exx - pb * eyy + (ci + (p2 <<< 1)) * exy;
        w[4] = xp * exx - yb * eyy - x2b * exy;
        w[5] = -xa * exx + yp * eyy - y2a * exy;
        for (int k = 0; k < 6; k++)
            v[k] = shift_tz(ci * w[k], 2 * COEF);
        d2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2]
           - ((v[0] * v[1] + v[0] * v[2] + v[1] * v[2]) <<< 1)
           + ((v[3] * v[3] + v[4] * v[4] + v[5] * v[5]) <<< 2);
        ddd = (d2 <= 0) ? 0 : floor_root(d2);
        l2 = shift_tz(v[0] + v[1] + v[2] + ddd, 1);
        if (l2 < 0)
            l2 = 0;
        lam = floor_root(l2 <<< FRAC);
        if (lam > wide_t'({VAR_W{1'b1}}))
        begin
            r.perr = {VAR_W{1'b1}};
            r.sat = 1'b1;
        end
        else
        begin
            r.perr = lam[VAR_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic track_t mk_track(logic [31:0] sx, logic [31:0] sy,
                                        logic [30:0] vx, logic [30:0] vy,
                                        logic [31:0] cxy);
        track_t t;
        t.sx = sx;
        t.sy = sy;
        t.vx = vx;
        t.vy = vy;
        t.cxy = cxy;
        return t;
    endfunction

    function automatic track_t rand_track();
        track_t t;
        int mode;
        mode = $urandom_range(0, 9);
        t.sx = $urandom;
        t.sy = $urandom;
        t.vx = $urandom;
        t.vy = $urandom;
        t.cxy = $urandom;
        if (mode < 6)
        begin
            t.sx = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
            t.sy = $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000;
        end
        if (mode < 3)
        begin
            t.vx = $urandom_range(0, 24'hFFFFFF);
            t.vy = $urandom_range(0, 24'hFFFFFF);
            t.cxy = $signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000;
        end
        return t;
    endfunction

    initial
    begin
        pending_tracks.push_back(mk_track(0, 0, 0, 0, 0));
        pending_tracks.push_back(mk_track(0, 0, 31'h10000, 31'h10000, 0));
        pending_tracks.push_back(mk_track(32'h7FFFFFFF, 32'h7FFFFFFF,
                                          31'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF));
        pending_tracks.push_back(mk_track(32'h80000000, 32'h80000000,
                                          31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000));
        pending_tracks.push_back(mk_track(32'h7FFFFFFF, 32'h80000000, 0, 0, 32'h7FFFFFFF));
        pending_tracks.push_back(mk_track(0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h7FFFFFFF));
        pending_tracks.push_back(mk_track(0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000));
        pending_tracks.push_back(mk_track(0, 0, 0, 0, 32'h80000000));
        pending_tracks.push_back(mk_track(0, 0, 0, 0, 32'h7FFFFFFF));
        pending_tracks.push_back(mk_track(32'h10000, 32'hFFFF0000, 31'h8000, 31'h20000,
                                          32'hFFFFC000));
        pending_tracks.push_back(mk_track(32'hFFFFFFFF, 1, 1, 1, 32'hFFFFFFFF));
        pending_tracks.push_back(mk_track(32'h00010000, 0, 31'h7FFFFFFF, 0, 0));
        pending_tracks.push_back(mk_track(0, 32'h00010000, 0, 31'h7FFFFFFF, 0));
        pending_tracks.push_back(mk_track(32'h00008000, 32'hFFFF8000, 31'h00010000,
                                          31'h00010000, 32'h80000000));
        pending_tracks.push_back(mk_track(32'h55555555, 32'hAAAAAAAA, 31'h55555555,
                                          31'h2AAAAAAA, 32'hAAAAAAAA));
        for (int i = 0; i < N_RAND; i++)
            pending_tracks.push_back(rand_track());
        fill_done = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            expected_errs.push_back(pointing_of(mk_track(slope_x, slope_y, var_x,
                                                         var_y, cov_xy)));
        if (out_valid && !out_stall)
        begin
            if (expected_errs.size() == 0)
            begin
                $error("unexpected output transaction: pointing_error=%0h saturated=%0b",
                       pointing_error, saturated);
                errors = errors + 1;
            end
            else
            begin
                if (pointing_error !== expected_errs[0].perr)
                begin
                    $error("pointing_error: expected %0h actual %0h",
                           expected_errs[0].perr, pointing_error);
                    errors = errors + 1;
                end
                if (saturated !== expected_errs[0].sat)
                begin
                    $error("saturated: expected %0b actual %0b",
                           expected_errs[0].sat, saturated);
                    errors = errors + 1;
                end
                if (saturated === 1'b1)
                    sat_seen <= sat_seen + 1;
                void'(expected_errs.pop_front());
                checked <= checked + 1;
            end
        end
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (fill_done && pending_tracks.size() > 0
                     && !(sent == DRAIN_AT && expected_errs.size() > 0))
            begin
                slope_x <= pending_tracks[0].sx;
                slope_y <= pending_tracks[0].sy;
                var_x <= pending_tracks[0].vx;
                var_y <= pending_tracks[0].vy;
                cov_xy <= pending_tracks[0].cxy;
                void'(pending_tracks.pop_front());
                in_valid <= 1'b1;
                sent <= sent + 1;
                in_gap <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                out_gap <= gap_len();
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (fill_done && pending_tracks.size() == 0);
        @(posedge clk);
        while (in_valid || expected_errs.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d tracks: directed slope/variance extremes and random mixes",
                 checked);
        $display("with random gaps on both channels, one full drain, %0d saturated", sat_seen);
        if (errors == 0 && expected_errs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
